// File: sv/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the binary to bcd step of the formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int ValueW     = 32;
    localparam int DigitW     = 4;
    localparam int DecDigits  = 10;
    localparam int BcdW       = DecDigits * DigitW;
    localparam int CharW      = 7;
    localparam int StepBits   = 8;
    localparam int NumStages  = ValueW / StepBits;
    localparam int PtrW       = $clog2(DecDigits);
    localparam int HexDigits  = ValueW / DigitW;
    localparam int AddrW      = 3;
    localparam int DataW      = 32;
    localparam int Dec16Digits = 5;
    localparam int Hex16Digits = 4;
    localparam int PrefixLen  = 2;

    localparam logic [AddrW-3:0] RegHexLower = 1'b0;

    localparam logic [CharW-1:0] ChZero   = 7'h30;
    localparam logic [CharW-1:0] ChX      = 7'h78;
    localparam logic [CharW-1:0] ChUpperA = 7'h41;
    localparam logic [CharW-1:0] ChLowerA = 7'h61;

    typedef enum logic [2:0] {
        OP_DEC16     = 3'd0,
        OP_DEC16_PAD = 3'd1,
        OP_DEC32     = 3'd2,
        OP_DEC32_PAD = 3'd3,
        OP_HEX16_PFX = 3'd4,
        OP_HEX16_PAD = 3'd5,
        OP_HEX32_PFX = 3'd6,
        OP_NONE      = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [BcdW-1:0]   bcd;
        logic [ValueW-1:0] value;
        t_opcode           opcode;
    } t_conv;

    // shift-add-3 over one byte of the binary value, msb first
    function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd_in,
                                                    input logic [StepBits-1:0] bits);
        logic [BcdW-1:0] b;
        b = bcd_in;
        for (int i = StepBits - 1; i >= 0; i--) begin
            for (int d = 0; d < DecDigits; d++) begin
                if (b[d*DigitW +: DigitW] >= 4'd5) begin
                    b[d*DigitW +: DigitW] = b[d*DigitW +: DigitW] + 4'd3;
                end
            end
            b = {b[BcdW-2:0], bits[i]};
        end
        return b;
    endfunction

endpackage

// File: sv/itoa_bcd.sv
// ----------------------------------------------------------------------------
// itoa_bcd
// Pipelined binary to bcd conversion, one byte of the value per stage.
// ----------------------------------------------------------------------------
module itoa_bcd (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [31:0]              i_value,
    input  itoa_pkg::t_opcode        i_opcode,
    output logic                     o_valid,
    input  logic                     i_ready,
    output itoa_pkg::t_conv          o_conv
);
    import itoa_pkg::*;

    t_conv             r_stage [NumStages];
    logic [NumStages-1:0] r_vld;
    t_conv             n_stage [NumStages];
    logic [NumStages-1:0] w_src_vld;
    logic [NumStages-1:0] w_rdy;
    t_conv             w_src   [NumStages];
    t_conv             w_entry;

    // 16-bit forms see only the low half from here on
    always_comb begin
        w_entry.bcd    = '0;
        w_entry.opcode = i_opcode;
        case (i_opcode) inside
            OP_DEC16, OP_DEC16_PAD, OP_HEX16_PFX, OP_HEX16_PAD: begin
                w_entry.value = {{(ValueW-16){1'b0}}, i_value[15:0]};
            end
            default: begin
                w_entry.value = i_value;
            end
        endcase
    end

    always_comb begin
        w_src[0]     = w_entry;
        w_src_vld[0] = i_valid;
        for (int k = 1; k < NumStages; k++) begin
            w_src[k]     = r_stage[k-1];
            w_src_vld[k] = r_vld[k-1];
        end
        for (int k = 0; k < NumStages; k++) begin
            n_stage[k]     = w_src[k];
            n_stage[k].bcd = dabble_step(w_src[k].bcd,
                                         w_src[k].value[ValueW-1-k*StepBits -: StepBits]);
        end
    end

    always_comb begin
        w_rdy[NumStages-1] = !r_vld[NumStages-1] || i_ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NumStages; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_src_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumStages; k++) begin
            if (w_rdy[k] && w_src_vld[k]) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NumStages-1];
    assign o_conv  = r_stage[NumStages-1];

endmodule

// File: sv/itoa_ser.sv
// ----------------------------------------------------------------------------
// itoa_ser
// Character sequencer: prefix, then digits from the most significant shown.
// ----------------------------------------------------------------------------
module itoa_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  itoa_pkg::t_conv              i_conv,
    input  logic                         i_hex_lower,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [itoa_pkg::CharW-1:0]   o_character,
    output logic                         o_last
);
    import itoa_pkg::*;

    logic              r_busy;
    logic [1:0]        r_pre;
    logic [PtrW-1:0]   r_ptr;
    logic [DigitW-1:0] r_dig [DecDigits];

    logic [DigitW-1:0] w_dig [DecDigits];
    logic [PtrW-1:0]   w_msd;
    logic [PtrW-1:0]   w_start;
    logic [1:0]        w_pre;
    logic              w_hex;
    logic              w_last;
    logic              w_load;
    logic [DigitW-1:0] w_cur;

    always_comb begin
        case (i_conv.opcode) inside
            OP_HEX16_PFX, OP_HEX16_PAD, OP_HEX32_PFX: w_hex = 1'b1;
            default:                                  w_hex = 1'b0;
        endcase
        for (int d = 0; d < DecDigits; d++) begin
            if (!w_hex) begin
                w_dig[d] = i_conv.bcd[d*DigitW +: DigitW];
            end else if (d < HexDigits) begin
                w_dig[d] = i_conv.value[d*DigitW +: DigitW];
            end else begin
                w_dig[d] = '0;
            end
        end
        // highest non-zero digit, the units digit when all are zero
        w_msd = '0;
        for (int d = 1; d < DecDigits; d++) begin
            if (w_dig[d] != '0) begin
                w_msd = PtrW'(d);
            end
        end
        case (i_conv.opcode)
            OP_DEC16_PAD: w_start = PtrW'(Dec16Digits - 1);
            OP_DEC32_PAD: w_start = PtrW'(DecDigits - 1);
            OP_HEX16_PAD: w_start = PtrW'(Hex16Digits - 1);
            default:      w_start = w_msd;
        endcase
        case (i_conv.opcode) inside
            OP_HEX16_PFX, OP_HEX32_PFX: w_pre = 2'(PrefixLen);
            default:                    w_pre = 2'd0;
        endcase
    end

    assign w_last  = (r_pre == 2'd0) && (r_ptr == '0);
    assign o_ready = !r_busy || (i_ready && w_last);
    assign w_load  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pre  <= 2'd0;
            r_ptr  <= '0;
        end else if (o_ready) begin
            r_busy <= i_valid && (i_conv.opcode != OP_NONE);
            r_pre  <= w_pre;
            r_ptr  <= w_start;
        end else if (i_ready) begin
            if (r_pre != 2'd0) begin
                r_pre <= r_pre - 2'd1;
            end else begin
                r_ptr <= r_ptr - PtrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int d = 0; d < DecDigits; d++) begin
                r_dig[d] <= w_dig[d];
            end
        end
    end

    assign w_cur = r_dig[r_ptr];

    always_comb begin
        if (r_pre == 2'd2) begin
            o_character = ChZero;
        end else if (r_pre == 2'd1) begin
            o_character = ChX;
        end else if (w_cur <= 4'd9) begin
            o_character = ChZero + CharW'(w_cur);
        end else begin
            o_character = (i_hex_lower ? ChLowerA : ChUpperA) + CharW'(w_cur - 4'd10);
        end
    end

    assign o_valid = r_busy;
    assign o_last  = w_last;

endmodule

// File: sv/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats an unsigned value as decimal or hex ascii text, one character per item.
// ----------------------------------------------------------------------------
// A value enters a four-stage binary to bcd pipeline (one byte per stage) and
// can be taken every cycle while that pipeline has room. A character sequencer
// then sends one character per cycle while the output is ready: a value gives
// as many characters as it shows (1 to 10, the "0x" prefix included), and an
// unused opcode is dropped with no output. Register 0 at byte address 0 holds
// the hex letter case (bit 0: 0 upper, 1 lower); change it only while the
// block is idle.
module integer_to_ascii_formatter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [31:0]                 i_value,
    input  logic [2:0]                  i_opcode,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [6:0]                  o_character,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itoa_pkg::AddrW-1:0]  paddr,
    input  logic [itoa_pkg::DataW-1:0]  pwdata,
    output logic [itoa_pkg::DataW-1:0]  prdata,
    output logic                        pready
);
    import itoa_pkg::*;

    logic    r_hex_lower;
    logic    w_conv_valid;
    logic    w_conv_ready;
    t_conv   w_conv;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_lower <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[AddrW-1:2] == RegHexLower)) begin
            r_hex_lower <= pwdata[0];
        end
    end

    always_comb begin
        unique case (paddr[AddrW-1:2])
            RegHexLower: prdata = {{(DataW-1){1'b0}}, r_hex_lower};
            default:     prdata = '0;
        endcase
    end

    itoa_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_value  (i_value),
        .i_opcode (t_opcode'(i_opcode)),
        .o_valid  (w_conv_valid),
        .i_ready  (w_conv_ready),
        .o_conv   (w_conv)
    );

    itoa_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_conv_valid),
        .o_ready     (w_conv_ready),
        .i_conv      (w_conv),
        .i_hex_lower (r_hex_lower),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
